@@ rtl/b64c_pkg.sv @@
`timescale 1ns / 1ps

package b64c_pkg;

    localparam logic [7:0] CHAR_PAD = 8'h3D;   // '='
    localparam logic [7:0] CHAR_PLUS = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F; // '/'

    // register index of the direction register
    localparam logic REG_DIRECTION = 1'b0;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // one group's worth of results; data[0] leaves first
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      count;
        logic            last;
    } b64c_job_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            r = CHAR_PLUS;
        end else begin
            r = CHAR_SLASH;
        end
        return r;
    endfunction

    // characters outside the alphabet map to zero
    function automatic logic [5:0] dec_char(input logic [7:0] c);
        logic [5:0] r;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = 6'(c - 8'h30 + 8'd52);
        end else if (c == CHAR_PLUS) begin
            r = 6'd62;
        end else if (c == CHAR_SLASH) begin
            r = 6'd63;
        end else begin
            r = 6'd0;
        end
        return r;
    endfunction

endpackage

@@ rtl/b64c_front.sv @@
`timescale 1ns / 1ps

// Group assembly: gathers items into groups and hands finished groups on as jobs.
module b64c_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                direction,
    input  logic                cfg_clear,
    input  logic                in_fire,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                job_push,
    output b64c_pkg::b64c_job_t job
);

    logic [1:0]  phase_reg, phase_next;
    logic [17:0] accum_reg, accum_next;
    logic        pad_reg, pad_next;

    logic [15:0] acc16;
    logic [23:0] v24;
    logic [5:0]  sext;
    logic        is_pad;

    always_comb begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        pad_next   = pad_reg;
        job_push   = 1'b0;
        job        = '0;
        acc16      = {accum_reg[7:0], in_byte};
        v24        = '0;
        sext       = b64c_pkg::dec_char(in_byte);
        is_pad     = (in_byte == b64c_pkg::CHAR_PAD);

        if (in_fire) begin
            if (direction == b64c_pkg::DIR_ENCODE) begin
                if (!phase_reg[1]) begin
                    accum_next = {2'b00, acc16};
                    phase_next = phase_reg + 2'd1;
                    if (in_last) begin
                        // short group: pad out to four characters
                        v24 = (phase_reg == 2'd0) ? {acc16[7:0], 16'h0000}
                                                  : {acc16, 8'h00};
                        job.data[0] = b64c_pkg::enc_char(v24[23:18]);
                        job.data[1] = b64c_pkg::enc_char(v24[17:12]);
                        job.data[2] = (phase_reg == 2'd0) ? b64c_pkg::CHAR_PAD
                                                          : b64c_pkg::enc_char(v24[11:6]);
                        job.data[3] = b64c_pkg::CHAR_PAD;
                        job.count   = 3'd4;
                        job.last    = 1'b1;
                        job_push    = 1'b1;
                    end
                end else begin
                    v24 = {accum_reg[15:0], in_byte};
                    job.data[0] = b64c_pkg::enc_char(v24[23:18]);
                    job.data[1] = b64c_pkg::enc_char(v24[17:12]);
                    job.data[2] = b64c_pkg::enc_char(v24[11:6]);
                    job.data[3] = b64c_pkg::enc_char(v24[5:0]);
                    job.count   = 3'd4;
                    job.last    = in_last;
                    job_push    = 1'b1;
                    phase_next  = 2'd0;
                    accum_next  = '0;
                end
            end else begin
                if (phase_reg != 2'd3) begin
                    if (phase_reg == 2'd2 && is_pad) begin
                        pad_next = 1'b1;
                        sext     = 6'd0;
                    end
                    accum_next = {accum_reg[11:0], sext};
                    phase_next = phase_reg + 2'd1;
                end else begin
                    v24 = {accum_reg, 6'd0};
                    if (pad_reg) begin
                        job.count = 3'd1;
                    end else if (is_pad) begin
                        job.count = 3'd2;
                    end else begin
                        v24[5:0]  = sext;
                        job.count = 3'd3;
                    end
                    job.data[0] = v24[23:16];
                    job.data[1] = v24[15:8];
                    job.data[2] = v24[7:0];
                    job.data[3] = 8'h00;
                    job.last    = in_last;
                    job_push    = 1'b1;
                    phase_next  = 2'd0;
                    accum_next  = '0;
                    pad_next    = 1'b0;
                end
            end
            if (in_last) begin
                phase_next = 2'd0;
                accum_next = '0;
                pad_next   = 1'b0;
            end
        end

        if (cfg_clear) begin
            phase_next = 2'd0;
            accum_next = '0;
            pad_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
            accum_reg <= '0;
            pad_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            pad_reg   <= pad_next;
        end
    end

endmodule

@@ rtl/b64c_fifo.sv @@
`timescale 1ns / 1ps

// Small job queue between group assembly and the output serializer.
module b64c_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  b64c_pkg::b64c_job_t push_job,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output b64c_pkg::b64c_job_t pop_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64c_pkg::b64c_job_t mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/b64c_back.sv @@
`timescale 1ns / 1ps

// Serializer: unloads one job at a time, one byte per cycle while m_ready allows, into the output register.
module b64c_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_empty,
    input  b64c_pkg::b64c_job_t job,
    output logic                job_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_out_last
);

    logic [3:0][7:0] cur_data_reg, cur_data_next;
    logic [2:0]      cur_cnt_reg, cur_cnt_next;
    logic            cur_last_reg, cur_last_next;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_byte_reg, m_byte_next;
    logic            m_last_reg, m_last_next;
    logic            out_load, emit;

    assign out_load = !m_valid_reg || m_ready;
    assign emit     = out_load && (cur_cnt_reg != 3'd0);
    // refill as soon as the held job is gone or leaves its final byte now
    assign job_pop  = !job_empty && ((cur_cnt_reg == 3'd0) || (emit && cur_cnt_reg == 3'd1));

    always_comb begin
        cur_data_next = cur_data_reg;
        cur_cnt_next  = cur_cnt_reg;
        cur_last_next = cur_last_reg;
        m_valid_next  = m_valid_reg;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;

        if (out_load) begin
            m_valid_next = emit;
        end
        if (emit) begin
            m_byte_next   = cur_data_reg[0];
            m_last_next   = cur_last_reg && (cur_cnt_reg == 3'd1);
            cur_data_next = {8'h00, cur_data_reg[3:1]};
            cur_cnt_next  = cur_cnt_reg - 3'd1;
        end
        if (job_pop) begin
            cur_data_next = job.data;
            cur_cnt_next  = job.count;
            cur_last_next = job.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_cnt_reg <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_cnt_reg <= cur_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_data_reg <= cur_data_next;
        cur_last_reg <= cur_last_next;
        m_byte_reg   <= m_byte_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;

endmodule

@@ rtl/base64_stream_codec_core.sv @@
`timescale 1ns / 1ps

// Streaming Base64 codec (standard alphabet, '+' and '/', '=' padding). The direction
// register at byte address 0 (bit 0: 0 encode, 1 decode) selects the mode; writing it
// also drops any partly gathered group, so write it only with the stream idle. In
// encode mode every three bytes yield four characters, and a request flagged last
// with one or two bytes pending yields a padded quad. In decode mode every four
// characters yield three bytes, or fewer when '=' sits in the third or fourth place;
// characters outside the alphabet count as zero, and an unfinished group at the end
// of a stream is silently dropped (that stream then carries no last flag). The input
// side takes one request per cycle while the job queue has room; the output side
// sends one byte per cycle from a registered output while m_ready is high. Encoding
// is bounded by the output channel, as three input bytes make four characters;
// decoding sustains one character per cycle. A result reaches m_valid through the
// job queue, the serializer's held job and the output register.
module base64_stream_codec_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic direction_reg, direction_next;
    logic cfg_write;
    logic in_fire;
    logic fifo_full, fifo_empty;
    logic job_push, job_pop;
    b64c_pkg::b64c_job_t front_job, queue_job;

    // APB: zero wait states, paddr[2] picks the register word
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == b64c_pkg::REG_DIRECTION);
    assign prdata    = (paddr[2] == b64c_pkg::REG_DIRECTION) ? {31'd0, direction_reg}
                                                             : 32'd0;

    always_comb begin
        direction_next = direction_reg;
        if (cfg_write) begin
            direction_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= b64c_pkg::DIR_ENCODE;
        end else begin
            direction_reg <= direction_next;
        end
    end

    // front end is never blocked by the output side except through the queue
    assign s_ready = !fifo_full;
    assign in_fire = s_valid && s_ready;

    b64c_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .direction (direction_reg),
        .cfg_clear (cfg_write),
        .in_fire   (in_fire),
        .in_byte   (s_in_byte),
        .in_last   (s_in_last),
        .job_push  (job_push),
        .job       (front_job)
    );

    b64c_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (front_job),
        .full     (fifo_full),
        .pop      (job_pop),
        .empty    (fifo_empty),
        .pop_job  (queue_job)
    );

    b64c_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_empty  (fifo_empty),
        .job        (queue_job),
        .job_pop    (job_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

endmodule

@@ rtl/b64c_checker.sv @@
`timescale 1ns / 1ps

module b64c_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_out_last,
    input logic [31:0] prdata,
    input logic        pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_out_last))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_pready: assert property (@(posedge aclk)
        pready)
        else $error("pready dropped");

    a_prdata_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        prdata[31:1] == 31'd0)
        else $error("unused register bits read nonzero");

endmodule

bind base64_stream_codec_core b64c_checker u_b64c_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_out_last (m_out_last),
    .prdata     (prdata),
    .pready     (pready)
);

@@ tb/b64c_stream_checker.sv @@
`timescale 1ns / 1ps

// Watches both stream channels and the APB port of the Base64 codec, keeps its own
// copy of the group state, and checks every result in order.
module b64c_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatches,
    output int          results_due
);

    localparam logic [2:0] DIRECTION_ADDR = {b64c_pkg::REG_DIRECTION, 2'b00};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } b64_result_t;

    b64_result_t b64_results_due[$];

    logic        dir_mode;
    logic [1:0]  grp_phase;
    logic [17:0] grp_accum;
    logic        grp_pad;
    int          err_count = 0;

    assign mismatches = err_count;

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 26) return 8'h41 + 8'(v);
        if (v < 52) return 8'h61 + 8'(v - 26);
        if (v < 62) return 8'h30 + 8'(v - 52);
        return (v == 6'd62) ? b64c_pkg::CHAR_PLUS : b64c_pkg::CHAR_SLASH;
    endfunction

    // inverse lookup; anything not in the alphabet is zero
    function automatic logic [5:0] char_sextet(input logic [7:0] c);
        for (int i = 0; i < 64; i++) begin
            if (sextet_char(6'(i)) == c) return 6'(i);
        end
        return 6'd0;
    endfunction

    task automatic clear_group();
        grp_phase = '0;
        grp_accum = '0;
        grp_pad   = 1'b0;
    endtask

    task automatic predict_b64_results(input logic [7:0] b, input logic last);
        logic [7:0]  res [4];
        logic [23:0] v;
        logic [5:0]  s;
        int          n;
        n = 0;
        if (dir_mode == b64c_pkg::DIR_ENCODE) begin
            if (grp_phase < 2) begin
                grp_accum = {2'b00, grp_accum[7:0], b};
                grp_phase = grp_phase + 2'd1;
                if (last) begin
                    v = (grp_phase == 2'd1) ? {grp_accum[7:0], 16'h0000}
                                            : {grp_accum[15:0], 8'h00};
                    res[0] = sextet_char(v[23:18]);
                    res[1] = sextet_char(v[17:12]);
                    res[2] = (grp_phase == 2'd1) ? b64c_pkg::CHAR_PAD
                                                 : sextet_char(v[11:6]);
                    res[3] = b64c_pkg::CHAR_PAD;
                    n = 4;
                end
            end else begin
                v = {grp_accum[15:0], b};
                res[0] = sextet_char(v[23:18]);
                res[1] = sextet_char(v[17:12]);
                res[2] = sextet_char(v[11:6]);
                res[3] = sextet_char(v[5:0]);
                n = 4;
                clear_group();
            end
        end else begin
            s = char_sextet(b);
            if (grp_phase < 3) begin
                // among the first three slots, '=' only counts as padding in the third
                if (grp_phase == 2'd2 && b == b64c_pkg::CHAR_PAD) begin
                    grp_pad = 1'b1;
                    s = '0;
                end
                grp_accum = {grp_accum[11:0], s};
                grp_phase = grp_phase + 2'd1;
            end else begin
                v = {grp_accum, 6'd0};
                if (grp_pad) begin
                    n = 1;
                end else if (b == b64c_pkg::CHAR_PAD) begin
                    n = 2;
                end else begin
                    v[5:0] = s;
                    n = 3;
                end
                res[0] = v[23:16];
                res[1] = v[15:8];
                res[2] = v[7:0];
                clear_group();
            end
        end
        for (int k = 0; k < n; k++)
            b64_results_due.push_back('{data: res[k], last: last && (k == n - 1)});
        if (last) clear_group();
    endtask

    always @(posedge aclk) begin
        b64_result_t want;
        if (!aresetn) begin
            dir_mode = b64c_pkg::DIR_ENCODE;
            clear_group();
            b64_results_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (b64_results_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result byte %02h last %0b",
                                            m_out_byte, m_out_last));
                end else begin
                    want = b64_results_due.pop_front();
                    if (m_out_byte !== want.data)
                        flag_mismatch($sformatf("out_byte %02h, want %02h",
                                                m_out_byte, want.data));
                    if (m_out_last !== want.last)
                        flag_mismatch($sformatf("out_last %0b, want %0b (byte %02h)",
                                                m_out_last, want.last, want.data));
                end
            end
            if (s_valid && s_ready)
                predict_b64_results(s_in_byte, s_in_last);
            if (psel && penable && pwrite && pready && paddr == DIRECTION_ADDR) begin
                dir_mode = pwdata[0];
                clear_group();
            end
        end
        results_due <= b64_results_due.size();
    end

endmodule

@@ tb/tb_base64_stream_codec_core.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the Base64 stream codec. Checking lives in the checker
// instance; this module only drives the block and decides pass or fail.
module tb_base64_stream_codec_core;

    localparam logic [2:0] DIRECTION_ADDR = {b64c_pkg::REG_DIRECTION, 2'b00};
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int PHASE_ITEMS   = 26;      // minimum requests per random phase

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_in_last;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_out_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int results_due;
    int cycle_count = 0;

    // sender pacing: requests go out in bursts, gaps between bursts
    int burst_left  = 0;
    int phase_items = 0;
    bit idle_free   = 1'b0;

    // receiver stall pattern state
    int rx_mode    = 0;
    int stall_left = 0;

    base64_stream_codec_core u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    b64c_stream_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatch_count),
        .results_due (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: picks among three behaviors - always ready, random drops of ready,
    // or occasional long stalls.
    always @(posedge aclk) begin
        if (cycle_count % 97 == 0)
            rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_left != 0) begin
                    stall_left <= stall_left - 1;
                    m_ready    <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_left <= $urandom_range(1, 10);
                end
            end
        endcase
    end

    // stimulus-side alphabet, used to build well-formed character streams
    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        if (v < 26) return 8'h41 + 8'(v);
        if (v < 52) return 8'h61 + 8'(v - 26);
        if (v < 62) return 8'h30 + 8'(v - 52);
        return (v == 6'd62) ? b64c_pkg::CHAR_PLUS : b64c_pkg::CHAR_SLASH;
    endfunction

    // One request. Valid stays high into the next request unless a gap is taken,
    // so back-to-back requests never lower and raise valid in the same step.
    task automatic send_request(input logic [7:0] b, input logic last);
        int gap;
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
        phase_items++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = idle_free ? 0 : $urandom_range(0, 6);
            burst_left = $urandom_range(0, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_text(input string txt, input bit mark_last);
        for (int i = 0; i < txt.len(); i++)
            send_request(txt[i], mark_last && (i == txt.len() - 1));
    endtask

    // Hold the sender until the checker has seen every predicted result, then give
    // the block time to finish a request that produces nothing (partial decode group).
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; pready is tied high in the block
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Encode stream: mostly short (exercises both padded tails), some longer runs.
    // One in ten has no last flag, so its tail carries into the next stream.
    task automatic send_encode_stream();
        int  len;
        bit  mark;
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
        mark = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < len; i++)
            send_request(8'($urandom_range(0, 255)), mark && (i == len - 1));
    endtask

    // Decode stream: mostly valid Base64 built from whole quads, closing quad padded
    // at random (sometimes mid-stream too), with sparse noise - stray '=' or any byte -
    // and now and then a truncated closing quad.
    task automatic send_decode_stream();
        logic [7:0] chars[$];
        int         groups;
        int         pad_kind;
        bit         mark;
        groups = $urandom_range(1, 3);
        for (int g = 0; g < groups; g++) begin
            for (int k = 0; k < 4; k++)
                chars.push_back(b64_symbol(6'($urandom_range(0, 63))));
            if (g == groups - 1 || $urandom_range(0, 9) == 0) begin
                pad_kind = $urandom_range(0, 2);
                if (pad_kind >= 1)
                    chars[chars.size() - 1] = b64c_pkg::CHAR_PAD;
                if (pad_kind == 2) begin
                    chars[chars.size() - 2] = b64c_pkg::CHAR_PAD;
                    // after a third-slot pad the fourth character is don't-care
                    if ($urandom_range(0, 3) == 0)
                        chars[chars.size() - 1] = 8'($urandom_range(0, 255));
                end
            end
        end
        foreach (chars[i]) begin
            if ($urandom_range(0, 11) == 0)
                chars[i] = $urandom_range(0, 1) ? b64c_pkg::CHAR_PAD
                                                : 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) void'(chars.pop_back());
        mark = ($urandom_range(0, 9) != 0);
        foreach (chars[i])
            send_request(chars[i], mark && (i == chars.size() - 1));
    endtask

    initial begin
        logic dir;
        s_valid   <= 1'b0;
        s_in_byte <= '0;
        s_in_last <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        aresetn   <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed encode: full quad of extremes, both padded tails, full quad at end
        apb_write(DIRECTION_ADDR, {31'd0, b64c_pkg::DIR_ENCODE});
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(8'h12, 1'b0);
        send_request(8'h34, 1'b0);
        send_request(8'h56, 1'b1);
        drain();

        // directed decode: third-slot pad with junk fourth char, fourth-slot pad,
        // then a normal quad after the pads with a leading '=' and an unknown char,
        // and finally a truncated quad that produces nothing
        apb_write(DIRECTION_ADDR, {31'd0, b64c_pkg::DIR_DECODE});
        send_text("+9=x", 1'b0);
        send_text("TWE=", 1'b0);
        send_text("=~z/", 1'b1);
        send_text("TW", 1'b1);
        drain();

        // random phases, alternating direction; two of them run with no sender gaps
        for (int ph = 0; ph < 8; ph++) begin
            dir = ph[0] ? b64c_pkg::DIR_DECODE : b64c_pkg::DIR_ENCODE;
            apb_write(DIRECTION_ADDR, {31'd0, dir});
            idle_free   = (ph == 2 || ph == 5);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if (dir == b64c_pkg::DIR_DECODE)
                    send_decode_stream();
                else
                    send_encode_stream();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_due == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
